// ===== hdl/rksk_pkg.sv =====
// Shared types, constants and the microcode program of the RC4 key schedule block.
`timescale 1ns / 1ps

package rksk_pkg;

  localparam int unsigned SboxAw    = 8;
  localparam int unsigned SboxDepth = 256;
  localparam int unsigned KeyCntW   = 9;
  localparam int unsigned UpcW      = 4;

  typedef logic [UpcW-1:0] upc_t;

  // Microcode step addresses.
  localparam upc_t UP_IDLE     = 4'd0;
  localparam upc_t UP_KEY      = 4'd1;
  localparam upc_t UP_SCH_INIT = 4'd2;
  localparam upc_t UP_SCH_A    = 4'd3;
  localparam upc_t UP_SCH_B    = 4'd4;
  localparam upc_t UP_SCH_C    = 4'd5;
  localparam upc_t UP_SCH_D    = 4'd6;
  localparam upc_t UP_SCH_END  = 4'd7;
  localparam upc_t UP_DAT_A    = 4'd8;
  localparam upc_t UP_DAT_B    = 4'd9;
  localparam upc_t UP_DAT_C    = 4'd10;
  localparam upc_t UP_DAT_D    = 4'd11;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS1,
    RD_POS1_SUM,
    RD_TMP_SUM,
    RD_N,
    RD_ACC_NEW
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_N_RDATA,
    WR_ACC_TMP
  } wr_sel_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_DISPATCH,
    JC_NOT_LAST,
    JC_NOT_NLAST
  } jmp_e;

  typedef struct packed {
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    latch;
    logic    key_wr;
    logic    key_rd;
    logic    sch_init;
    logic    acc_ld;
    logic    tmp_ld;
    logic    n_adv;
    logic    fin;
    logic    out_ld;
    logic    wait_out;
    jmp_e    jmp;
    upc_t    target;
  } cw_t;

  typedef struct packed {
    logic key_last;
    logic n_last;
    logic out_busy;
  } dp_stat_t;

  // Control store: one control word per step.
  function automatic cw_t ucode(upc_t upc);
    cw_t cw;
    cw = '0;
    cw.rd_sel = RD_NONE;
    cw.wr_sel = WR_NONE;
    cw.jmp    = JC_NEXT;
    cw.target = UP_IDLE;
    case (upc)
      UP_IDLE: begin
        cw.latch = 1'b1;
        cw.jmp   = JC_DISPATCH;
      end
      UP_KEY: begin
        cw.key_wr = 1'b1;
        cw.jmp    = JC_NOT_LAST;
        cw.target = UP_IDLE;
      end
      UP_SCH_INIT: begin
        cw.sch_init = 1'b1;
      end
      UP_SCH_A: begin
        cw.rd_sel = RD_N;
        cw.key_rd = 1'b1;
      end
      UP_SCH_B: begin
        cw.acc_ld = 1'b1;
        cw.tmp_ld = 1'b1;
        cw.rd_sel = RD_ACC_NEW;
      end
      UP_SCH_C: begin
        cw.wr_sel = WR_N_RDATA;
      end
      UP_SCH_D: begin
        cw.wr_sel = WR_ACC_TMP;
        cw.n_adv  = 1'b1;
        cw.jmp    = JC_NOT_NLAST;
        cw.target = UP_SCH_A;
      end
      UP_SCH_END: begin
        cw.fin    = 1'b1;
        cw.jmp    = JC_ALWAYS;
        cw.target = UP_IDLE;
      end
      UP_DAT_A: begin
        cw.rd_sel = RD_POS1;
      end
      UP_DAT_B: begin
        cw.tmp_ld = 1'b1;
        cw.rd_sel = RD_POS1_SUM;
      end
      UP_DAT_C: begin
        cw.rd_sel = RD_TMP_SUM;
      end
      UP_DAT_D: begin
        cw.out_ld   = 1'b1;
        cw.wait_out = 1'b1;
        cw.jmp      = JC_ALWAYS;
        cw.target   = UP_IDLE;
      end
      default: begin
        cw.jmp    = JC_ALWAYS;
        cw.target = UP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/rksk_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps

interface rksk_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_in;
  logic       key_last;

  modport source (output valid, output op, output byte_in, output key_last, input ready);
  modport sink   (input valid, input op, input byte_in, input key_last, output ready);
endinterface

interface rksk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// ===== hdl/rc4_key_schedule_static_keystream.sv =====
// Top level of the RC4 key schedule block with a fixed, non-swapping keystream.
`timescale 1ns / 1ps

// The byte of a key item is stored in the key store on the step after it is taken. The item
// that carries key_last also runs the key schedule, an init step, 256 rounds and an end
// step; each round reads the S-box twice and writes it twice through the single read port
// and single write port of the S-box memory. A data item makes three dependent reads of that
// memory with registered read data, and its last step holds while the output register is
// still full. The input is taken only when the sequencer is idle; a result sits in an output
// register so that the next item can be taken while it waits. The S-box comes out of reset
// as the identity permutation through per-entry valid bits, so no clearing pass is needed.

module rc4_key_schedule_static_keystream
  import rksk_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rksk_in_if.sink           in_i,
  rksk_out_if.source        out_o
);

  cw_t        cw;
  dp_stat_t   stat;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_data;

  rksk_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cw_o       (cw)
  );

  rksk_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cw_i        (cw),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.byte_in),
    .in_last_i   (in_i.key_last),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .stat_o      (stat)
  );

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.data_out = out_data;

endmodule

// ===== hdl/rksk_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module rksk_seq
  import rksk_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output cw_t      cw_o
);

  upc_t upc_q, upc_d;
  upc_t upc_inc;
  cw_t  cw;

  assign cw      = ucode(upc_q);
  assign cw_o    = cw;
  assign upc_inc = upc_q + upc_t'(1);

  assign in_ready_o = (upc_q == UP_IDLE);

  always_comb begin
    case (cw.jmp)
      JC_NEXT:      upc_d = upc_inc;
      JC_ALWAYS:    upc_d = cw.target;
      JC_DISPATCH:  upc_d = in_valid_i ? (in_op_i ? UP_DAT_A : UP_KEY) : upc_q;
      JC_NOT_LAST:  upc_d = stat_i.key_last ? upc_inc : cw.target;
      JC_NOT_NLAST: upc_d = stat_i.n_last ? upc_inc : cw.target;
      default:      upc_d = UP_IDLE;
    endcase
    // A step that delivers a result holds while the output register is still full.
    if (cw.wait_out && stat_i.out_busy) begin
      upc_d = upc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== hdl/rksk_dp.sv =====
// Datapath: S-box memory with valid bits, key store, index registers and output register.
`timescale 1ns / 1ps

module rksk_dp
  import rksk_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cw_t        cw_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_data_o,
  output dp_stat_t   stat_o
);

  localparam int unsigned KeyAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [7:0] sbox_mem [SboxDepth];
  logic [SboxDepth-1:0] sbox_vld_q;
  logic [7:0] key_mem [MAX_KEY_BYTES];

  logic [7:0]         byte_q;
  logic               last_q;
  logic [7:0]         pos_q;
  logic [7:0]         n_q;
  logic [7:0]         acc_q;
  logic [7:0]         tmp_q;
  logic [7:0]         kpos_q;
  logic [KeyCntW-1:0] key_cnt_q;
  logic [7:0]         key_rd_q;
  logic [7:0]         rdata_q;
  logic [7:0]         raddr_q;
  logic               rvld_q;
  logic               out_vld_q;
  logic [7:0]         out_data_q;

  logic [7:0]         sval;
  logic [7:0]         pos1;
  logic [7:0]         acc_new;
  logic               rd_en;
  logic [7:0]         rd_addr;
  logic               wr_en;
  logic [7:0]         wr_addr;
  logic [7:0]         wr_data;
  logic               out_busy;
  logic               can_store;
  logic [KeyCntW-1:0] kpos_inc;

  // An entry not written since reset or the start of the last schedule reads as its identity value.
  assign sval    = rvld_q ? rdata_q : raddr_q;
  assign pos1    = pos_q + 8'd1;
  assign acc_new = acc_q + sval + key_rd_q;

  assign out_busy  = out_vld_q && !out_ready_i;
  assign can_store = key_cnt_q < KeyCntW'(MAX_KEY_BYTES);
  assign kpos_inc  = {1'b0, kpos_q} + KeyCntW'(1);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = n_q;
    case (cw_i.rd_sel)
      RD_POS1:     rd_addr = pos1;
      RD_POS1_SUM: rd_addr = pos1 + sval;
      RD_TMP_SUM:  rd_addr = tmp_q + sval;
      RD_N:        rd_addr = n_q;
      RD_ACC_NEW:  rd_addr = acc_new;
      default:     rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = n_q;
    wr_data = sval;
    case (cw_i.wr_sel)
      WR_N_RDATA: begin
        wr_addr = n_q;
        wr_data = sval;
      end
      WR_ACC_TMP: begin
        wr_addr = acc_q;
        wr_data = tmp_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sbox_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= sbox_mem[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.key_wr && can_store) begin
      key_mem[key_cnt_q[KeyAw-1:0]] <= byte_q;
    end
    if (cw_i.key_rd) begin
      key_rd_q <= key_mem[kpos_q[KeyAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.latch && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (cw_i.tmp_ld) begin
      tmp_q <= sval;
    end
    if (out_vld_q == 1'b0 || out_ready_i) begin
      if (cw_i.out_ld) begin
        out_data_q <= byte_q ^ sval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbox_vld_q <= '0;
      rvld_q     <= 1'b0;
      pos_q      <= '0;
      n_q        <= '0;
      acc_q      <= '0;
      kpos_q     <= '0;
      key_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cw_i.sch_init) begin
        sbox_vld_q <= '0;
      end else if (wr_en) begin
        sbox_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= sbox_vld_q[rd_addr];
      end
      if (cw_i.sch_init) begin
        n_q    <= '0;
        acc_q  <= '0;
        kpos_q <= '0;
      end
      if (cw_i.acc_ld) begin
        acc_q <= acc_new;
      end
      if (cw_i.n_adv) begin
        n_q <= n_q + 8'd1;
        // The key repeats with the length of the stored key.
        if (kpos_inc >= key_cnt_q) begin
          kpos_q <= '0;
        end else begin
          kpos_q <= kpos_inc[7:0];
        end
      end
      if (cw_i.key_wr && can_store) begin
        key_cnt_q <= key_cnt_q + KeyCntW'(1);
      end
      if (cw_i.fin) begin
        key_cnt_q <= '0;
        pos_q     <= '0;
      end
      if (cw_i.out_ld && !out_busy) begin
        out_vld_q <= 1'b1;
        pos_q     <= pos_q + 8'd1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_data_o      = out_data_q;
  assign stat_o.key_last = last_q;
  assign stat_o.n_last   = (n_q == 8'(SboxDepth - 1));
  assign stat_o.out_busy = out_busy;

endmodule
